// ----- hw/rtl/sipq_pkg.sv -----
`default_nettype none

package sipq_pkg;

    localparam int DATA_W = 32;

    // request codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_SORTED = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_APPEND = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] pri;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        logic       capture;
        t_entry     item;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/sipq_if.sv -----
`default_nettype none

interface sipq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, output action, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input action, input item_value, input item_priority,
                    output ready);
endinterface

interface sipq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic               is_empty;
    logic               is_full;
    logic               dropped;

    modport source (output valid, output head_value, output head_priority,
                    output is_empty, output is_full, output dropped, input ready);
    modport sink   (input valid, input head_value, input head_priority,
                    input is_empty, input is_full, input dropped, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sipq_cell.sv -----
`default_nettype none

module sipq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sipq_pkg::t_cell_cmd i_cmd,
    input  wire logic [CW-1:0]     i_count,
    input  wire sipq_pkg::t_entry  i_left,
    input  wire sipq_pkg::t_entry  i_right,
    input  wire logic              i_found,
    output sipq_pkg::t_entry       o_ent,
    output logic                   o_found
);
    import sipq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_stay;
    logic   w_occupied;

    assign w_occupied = i_count > CW'(IDX);

    // insertion point is the first cell that does not keep its place
    assign o_found = i_found | ~r_stay;
    assign o_ent   = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_cmd.op)
            CELL_APPEND: begin
                if (i_count == CW'(IDX)) n_ent = i_cmd.item;
            end
            CELL_INSERT: begin
                if (i_found) begin
                    n_ent = i_left;
                end else if (!r_stay) begin
                    n_ent = i_cmd.item;
                end
            end
            CELL_POP:  n_ent = i_right;
            CELL_HOLD: n_ent = r_ent;
            default:   n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stay <= 1'b0;
        end else if (i_cmd.capture) begin
            r_stay <= w_occupied && !(r_ent.pri < i_cmd.item.pri);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_insert_priority_queue.sv -----
// a request goes through S_APPLY, then S_REPORT, which registers its response
// one request at a time (accept, shift the cell chain, load the response)
// the sorted push compares in every cell at transfer and shifts the chain in the next cycle
// the insertion point ripples through the cells as one or-gate per cell
// reset: synchronous, active low; the queue is empty after it, no clearing pass
`default_nettype none

module sorted_insert_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sipq_req_if.sink   i_req,
    sipq_rsp_if.source o_rsp
);
    import sipq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPLY  = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic [1:0]    r_act;
    t_entry        r_item;
    logic          r_drop;

    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic signed [31:0] r_out_pri;
    logic               r_out_empty;
    logic               r_out_full;
    logic               r_out_drop;

    t_cell_cmd w_cmd;
    t_entry    w_ent   [CAPACITY];
    logic      w_found [CAPACITY+1];
    logic      w_xfer_in;
    logic      w_full;
    logic      w_is_push;
    logic      w_load;

    assign w_full    = r_count == CW'(CAPACITY);
    assign w_is_push = (i_req.action == ACT_APPEND) || (i_req.action == ACT_SORTED);
    assign i_req.ready = r_state == S_IDLE;
    assign w_xfer_in   = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_REPORT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_cmd.capture    = w_xfer_in;
        w_cmd.item.value = w_xfer_in ? i_req.item_value : r_item.value;
        w_cmd.item.pri   = w_xfer_in ? i_req.item_priority : r_item.pri;
        w_cmd.op         = CELL_HOLD;
        if (r_state == S_APPLY && !r_drop) begin
            case (r_act)
                ACT_APPEND: w_cmd.op = CELL_APPEND;
                ACT_SORTED: w_cmd.op = CELL_INSERT;
                ACT_POP:    w_cmd.op = (r_count != '0) ? CELL_POP : CELL_HOLD;
                default:    w_cmd.op = CELL_HOLD;
            endcase
        end
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = w_cmd.item;
        end else begin : g_mid
            assign w_left = w_ent[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_ent[g];
        end else begin : g_inner
            assign w_right = w_ent[g+1];
        end
        sipq_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_found (w_found[g]),
            .o_ent   (w_ent[g]),
            .o_found (w_found[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer_in) begin
            r_act  <= i_req.action;
            r_item <= '{value: i_req.item_value, pri: i_req.item_priority};
            r_drop <= w_is_push && w_full;
        end
        if (w_load) begin
            r_out_value <= (r_count != '0) ? w_ent[0].value : '0;
            r_out_pri   <= (r_count != '0) ? w_ent[0].pri : '0;
            r_out_empty <= r_count == '0;
            r_out_full  <= w_full;
            r_out_drop  <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_xfer_in) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    case (w_cmd.op)
                        CELL_APPEND, CELL_INSERT: r_count <= r_count + CW'(1);
                        CELL_POP:                 r_count <= r_count - CW'(1);
                        default:                  r_count <= r_count;
                    endcase
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.head_value    = r_out_value;
    assign o_rsp.head_priority = r_out_pri;
    assign o_rsp.is_empty      = r_out_empty;
    assign o_rsp.is_full       = r_out_full;
    assign o_rsp.dropped       = r_out_drop;

endmodule

`default_nettype wire

// ----- hw/rtl/sipq_checker.sv -----
`default_nettype none

module sipq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [31:0] i_head_value,
    input wire logic [31:0] i_head_priority,
    input wire logic        i_is_empty,
    input wire logic        i_is_full,
    input wire logic        i_dropped
);

    // an empty queue reports a zero head
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_is_empty |-> i_head_value == '0 && i_head_priority == '0)
        else $error("empty queue reports a nonzero head");

    // a refused push only happens on a full queue, which cannot be empty too
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_dropped |-> i_is_full && !i_is_empty)
        else $error("dropped push without full queue");

    // one request in flight: no second transfer right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in flight");

    // stalled response stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_head_value))
        else $error("stalled response changed");

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_head_value    (o_rsp.head_value),
    .i_head_priority (o_rsp.head_priority),
    .i_is_empty      (o_rsp.is_empty),
    .i_is_full       (o_rsp.is_full),
    .i_dropped       (o_rsp.dropped)
);

`default_nettype wire

// ----- tb/sv/sorted_insert_priority_queue_tb.sv -----
`default_nettype none

module sorted_insert_priority_queue_tb;

    import sipq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] ACT_NOOP = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        t_idle_mode         mode;
    } t_request;

    typedef struct {
        logic signed [31:0] head_value;
        logic signed [31:0] head_priority;
        logic               is_empty;
        logic               is_full;
        logic               dropped;
    } t_head_report;

    logic i_clk;
    logic i_rst_n;

    sipq_req_if req_ch ();
    sipq_rsp_if rsp_ch ();

    sorted_insert_priority_queue #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_request     request_backlog[$];
    t_head_report head_reports_due[$];
    t_request     cur_req;
    t_idle_mode   cur_mode = IDLE_NONE;

    // shadow copy of the queue contents
    logic signed [31:0] shadow_value[CAPACITY];
    logic signed [31:0] shadow_prio[CAPACITY];
    int                 shadow_count = 0;

    int error_count   = 0;
    int checked_total = 0;
    int append_total  = 0;
    int sorted_total  = 0;
    int pop_total     = 0;
    int noop_total    = 0;
    int drop_total    = 0;
    int full_total    = 0;
    int quiet_cycles  = 0;

    function automatic int send_idle_pct(input t_idle_mode m);
        case (m)
            IDLE_SEND: return 61;
            IDLE_BOTH: return 16;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_idle_mode m);
        case (m)
            IDLE_RECV: return 61;
            IDLE_BOTH: return 16;
            default:   return 0;
        endcase
    endfunction

    function automatic t_head_report predict_head_report(input t_request r);
        t_head_report rep;
        int pos;
        rep.dropped = 1'b0;
        if (r.action == ACT_APPEND || r.action == ACT_SORTED) begin
            if (r.action == ACT_APPEND) begin
                append_total++;
            end else begin
                sorted_total++;
            end
            if (shadow_count >= CAPACITY) begin
                rep.dropped = 1'b1;
                drop_total++;
            end else begin
                pos = shadow_count;
                if (r.action == ACT_SORTED) begin
                    // equal priorities stay behind, first come first served
                    pos = 0;
                    while (pos < shadow_count && !(shadow_prio[pos] < r.prio))
                        pos++;
                end
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_value[k] = shadow_value[k-1];
                    shadow_prio[k]  = shadow_prio[k-1];
                end
                shadow_value[pos] = r.value;
                shadow_prio[pos]  = r.prio;
                shadow_count++;
                if (shadow_count == CAPACITY)
                    full_total++;
            end
        end else if (r.action == ACT_POP) begin
            pop_total++;
            if (shadow_count > 0) begin
                for (int k = 0; k < shadow_count - 1; k++) begin
                    shadow_value[k] = shadow_value[k+1];
                    shadow_prio[k]  = shadow_prio[k+1];
                end
                shadow_count--;
            end
        end else begin
            noop_total++;
        end
        if (shadow_count > 0) begin
            rep.head_value    = shadow_value[0];
            rep.head_priority = shadow_prio[0];
            rep.is_empty      = 1'b0;
        end else begin
            rep.head_value    = '0;
            rep.head_priority = '0;
            rep.is_empty      = 1'b1;
        end
        rep.is_full = (shadow_count >= CAPACITY);
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // narrow range half the time so that ties are common
    function automatic logic [31:0] random_priority();
        int t;
        t = $urandom_range(4);
        if ($urandom_range(1))
            return t - 2;
        return random_word();
    endfunction

    task automatic queue_request(input logic [1:0] action, input logic [31:0] value,
                                 input logic [31:0] prio, input t_idle_mode mode);
        t_request r;
        r.action = action;
        r.value  = value;
        r.prio   = prio;
        r.mode   = mode;
        request_backlog.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid)
                head_reports_due.push_back(predict_head_report(cur_req));
            if (request_backlog.size() > 0 &&
                $urandom_range(99) >= send_idle_pct(request_backlog[0].mode)) begin
                nxt = request_backlog.pop_front();
                cur_req              <= nxt;
                cur_mode             <= nxt.mode;
                req_ch.valid         <= 1'b1;
                req_ch.action        <= nxt.action;
                req_ch.item_value    <= nxt.value;
                req_ch.item_priority <= nxt.prio;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_head_report due;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (head_reports_due.size() == 0) begin
                    $display("%0t: response transfer with nothing expected, head %h", $time,
                             rsp_ch.head_value);
                    error_count++;
                end else begin
                    due = head_reports_due.pop_front();
                    check_field("head_value", due.head_value, rsp_ch.head_value);
                    check_field("head_priority", due.head_priority, rsp_ch.head_priority);
                    check_field("is_empty", 32'(due.is_empty), 32'(rsp_ch.is_empty));
                    check_field("is_full", 32'(due.is_full), 32'(rsp_ch.is_full));
                    check_field("dropped", 32'(due.dropped), 32'(rsp_ch.dropped));
                    checked_total++;
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct(cur_mode));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d responses outstanding", $time,
                         quiet_cycles, head_reports_due.size());
                $display("sorted_insert_priority_queue regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int         n;
        int         burst;
        int         push_bias;
        int         roll;
        logic [1:0] act;

        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_APPEND;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;

        // directed: empty queue corner cases, ordering, extremes, full queue
        queue_request(ACT_POP, 32'hdead_beef, 32'h0000_0001, IDLE_NONE);
        queue_request(ACT_NOOP, 32'h1234_5678, 32'h7fff_ffff, IDLE_NONE);
        queue_request(ACT_APPEND, 32'h1234_5678, 32'd5, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h7fff_ffff, 32'h7fff_ffff, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h8000_0000, 32'h8000_0000, IDLE_NONE);
        queue_request(ACT_SORTED, 32'hffff_ffff, 32'h0000_0000, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h0000_0000, 32'h0000_0000, IDLE_NONE);
        queue_request(ACT_APPEND, 32'h0000_0007, 32'h7fff_ffff, IDLE_NONE);
        queue_request(ACT_SORTED, 32'haaaa_aaaa, 32'hffff_ffff, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h5555_5555, 32'h0000_0001, IDLE_NONE);
        for (int k = 0; k < CAPACITY - 8; k++)
            queue_request((k % 2) ? ACT_SORTED : ACT_APPEND, random_word(),
                          random_priority(), IDLE_NONE);
        queue_request(ACT_APPEND, 32'h0bad_0bad, 32'h7fff_ffff, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h0bad_f00d, 32'h7fff_ffff, IDLE_NONE);
        queue_request(ACT_NOOP, 32'hffff_ffff, 32'hffff_ffff, IDLE_NONE);
        queue_request(ACT_POP, 32'h0000_0000, 32'h0000_0000, IDLE_NONE);
        queue_request(ACT_SORTED, 32'h0000_0042, 32'h7fff_ffff, IDLE_NONE);

        // random bursts leaning towards filling or draining, one idling mode per phase
        for (int ph = 0; ph < 4; ph++) begin
            n = 0;
            while (n < 90) begin
                burst     = $urandom_range(24, 6);
                push_bias = $urandom_range(1) ? 80 : 30;
                for (int b = 0; b < burst; b++) begin
                    roll = $urandom_range(99);
                    if (roll < 5)
                        act = ACT_NOOP;
                    else if (roll < 5 + push_bias * 95 / 100)
                        act = $urandom_range(1) ? ACT_SORTED : ACT_APPEND;
                    else
                        act = ACT_POP;
                    queue_request(act, random_word(), random_priority(), t_idle_mode'(ph));
                    n++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        while (head_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d append, %0d sorted, %0d pop, %0d no-op; %0d responses checked",
                 append_total, sorted_total, pop_total, noop_total, checked_total);
        $display("queue reached capacity %0d times, %0d pushes refused while full",
                 full_total, drop_total);
        if (error_count == 0) begin
            $display("sorted_insert_priority_queue regression: pass");
        end else begin
            $display("sorted_insert_priority_queue regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
